>>> rtl/bclru_pkg.sv
// ----------------------------------------------------------------------------
// bclru_pkg
// Shared types and constants of the block buffer cache lookup.
// ----------------------------------------------------------------------------
package bclru_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int DEV_W  = 8;
    localparam int BLK_W  = 27;
    localparam int CNT_W  = 8;
    localparam int TIME_W = 32;
    localparam int IDX_W  = 5;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // request kinds
    typedef enum logic [1:0] {
        MODE_GET     = 2'd0,
        MODE_RELEASE = 2'd1,
        MODE_PIN     = 2'd2,
        MODE_UNPIN   = 2'd3
    } mode_t;

    // completion codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_ZERO    = 2'd2
    } status_t;

    // one buffer entry as kept in the entry memory
    typedef struct packed {
        logic [DEV_W-1:0]  tag_device;
        logic [BLK_W-1:0]  tag_block;
        logic [CNT_W-1:0]  ref_count;
        logic [TIME_W-1:0] release_time;
        logic              data_valid;
    } entry_t;

    // control from the sequencer to the scan unit
    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

endpackage

>>> rtl/bclru_if.sv
// ----------------------------------------------------------------------------
// bclru_req_if / bclru_rsp_if
// Valid/ready channels for requests and results of the buffer cache lookup.
// ----------------------------------------------------------------------------
interface bclru_req_if;
    import bclru_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [DEV_W-1:0]  device;
    logic [BLK_W-1:0]  block_number;
    logic [IDX_W-1:0]  entry_index;
    logic [TIME_W-1:0] now_tick;

    modport source (
        output valid, mode, device, block_number, entry_index, now_tick,
        input  ready
    );
    modport sink (
        input  valid, mode, device, block_number, entry_index, now_tick,
        output ready
    );
endinterface

interface bclru_rsp_if;
    import bclru_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] result_entry;
    logic             was_hit;
    logic             needs_read;
    logic [1:0]       status;

    modport source (
        output valid, result_entry, was_hit, needs_read, status,
        input  ready
    );
    modport sink (
        input  valid, result_entry, was_hit, needs_read, status,
        output ready
    );
endinterface

>>> rtl/bclru_mem.sv
// ----------------------------------------------------------------------------
// bclru_mem
// Entry memory, one read and one write port, registered read data.
// Per-entry written bits make unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module bclru_mem #(
    parameter int NUM_ENTRIES = bclru_pkg::NUM_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(NUM_ENTRIES)-1:0] rd_addr,
    output bclru_pkg::entry_t              rd_word,
    input  logic                           wr_en,
    input  logic [$clog2(NUM_ENTRIES)-1:0] wr_addr,
    input  bclru_pkg::entry_t              wr_data
);
    import bclru_pkg::*;

    entry_t                 mem [NUM_ENTRIES];
    entry_t                 rd_word_reg;
    logic                   rd_written_reg;
    logic [NUM_ENTRIES-1:0] written_reg;

    // storage array and read data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // written bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    // unwritten entries hold their reset value of zero
    assign rd_word = rd_written_reg ? rd_word_reg : '0;

endmodule

>>> rtl/bclru_scan.sv
// ----------------------------------------------------------------------------
// bclru_scan
// Walks the entries as they stream out of memory: keeps the first tag match
// and the unreferenced entry with the oldest release time.
// ----------------------------------------------------------------------------
module bclru_scan #(
    parameter int NUM_ENTRIES = bclru_pkg::NUM_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bclru_pkg::scan_ctl_t               ctl,
    input  logic [bclru_pkg::DEV_W-1:0]        device,
    input  logic [bclru_pkg::BLK_W-1:0]        block_number,
    input  bclru_pkg::entry_t                  word,
    input  logic [$clog2(NUM_ENTRIES)-1:0]     addr,
    output logic                               hit,
    output logic [$clog2(NUM_ENTRIES)-1:0]     hit_idx,
    output bclru_pkg::entry_t                  hit_word,
    output logic                               found,
    output logic [$clog2(NUM_ENTRIES)-1:0]     pick_idx,
    output logic [bclru_pkg::TIME_W-1:0]       pick_time
);
    import bclru_pkg::*;

    localparam int IW = $clog2(NUM_ENTRIES);

    logic              hit_reg;
    logic [IW-1:0]     hit_idx_reg;
    entry_t            hit_word_reg;
    logic              found_reg;
    logic [IW-1:0]     pick_idx_reg;
    logic [TIME_W-1:0] pick_time_reg;
    logic              tag_match;
    logic              take_free;

    // per-entry compares
    assign tag_match = (word.tag_device == device) && (word.tag_block == block_number);
    assign take_free = (word.ref_count == '0) &&
                       (!found_reg || (word.release_time < pick_time_reg));

    // running match and oldest-free candidate, lowest index wins ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            found_reg     <= 1'b0;
            hit_idx_reg   <= '0;
            hit_word_reg  <= '0;
            pick_idx_reg  <= '0;
            pick_time_reg <= '0;
        end
        else if (ctl.clear)
        begin
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (ctl.sample)
        begin
            if (!hit_reg && tag_match)
            begin
                hit_reg      <= 1'b1;
                hit_idx_reg  <= addr;
                hit_word_reg <= word;
            end
            if (take_free)
            begin
                found_reg     <= 1'b1;
                pick_idx_reg  <= addr;
                pick_time_reg <= word.release_time;
            end
        end
    end

    assign hit       = hit_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_word  = hit_word_reg;
    assign found     = found_reg;
    assign pick_idx  = pick_idx_reg;
    assign pick_time = pick_time_reg;

endmodule

>>> rtl/block_cache_lookup_lru.sv
// ----------------------------------------------------------------------------
// block_cache_lookup_lru
// A get reads every entry in turn in S_SCAN, then passes S_LAST and S_FINISH;
//   release, pin and unpin read an in-range entry in S_FETCH, write it in S_FINISH.
// The next request is taken once the result sits in the output register,
//   even if stalled.
// Reset clears all entries at once through per-entry written bits.
// ----------------------------------------------------------------------------
module block_cache_lookup_lru #(
    parameter int NUM_ENTRIES = bclru_pkg::NUM_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bclru_req_if.sink   req,
    bclru_rsp_if.source rsp
);
    import bclru_pkg::*;

    localparam int            IW        = $clog2(NUM_ENTRIES);
    localparam logic [IW-1:0] LAST_ADDR = IW'(NUM_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_FETCH,
        S_FINISH
    } state_t;

    state_t            state_reg,      state_next;
    logic [IW-1:0]     cnt_reg,        cnt_next;
    logic              pend_reg,       pend_next;
    logic [IW-1:0]     pend_addr_reg,  pend_addr_next;
    logic [1:0]        mode_reg,       mode_next;
    logic [DEV_W-1:0]  dev_reg,        dev_next;
    logic [BLK_W-1:0]  blk_reg,        blk_next;
    logic [IDX_W-1:0]  idx_reg,        idx_next;
    logic [TIME_W-1:0] now_reg,        now_next;
    logic              oor_reg,        oor_next;
    logic              out_valid_reg,  out_valid_next;
    logic [IDX_W-1:0]  out_entry_reg,  out_entry_next;
    logic              out_hit_reg,    out_hit_next;
    logic              out_rd_reg,     out_rd_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic              accept;
    logic              load;
    scan_ctl_t         scan_ctl;

    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    entry_t            mem_rd_word;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    entry_t            mem_wr_data;

    logic              scan_hit;
    logic [IW-1:0]     scan_hit_idx;
    entry_t            scan_hit_word;
    logic              scan_found;
    logic [IW-1:0]     scan_pick_idx;
    logic [TIME_W-1:0] scan_pick_time;

    logic              fin_wr;
    entry_t            fin_word;
    logic [IW-1:0]     fin_addr;
    logic [IDX_W-1:0]  fin_entry;
    logic              fin_hit;
    logic              fin_rd;
    status_t           fin_status;

    // handshakes
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign load      = (state_reg == S_FINISH) && (!out_valid_reg || rsp.ready);

    // memory port use
    assign mem_rd_en   = (state_reg == S_SCAN) || (state_reg == S_FETCH);
    assign mem_rd_addr = (state_reg == S_SCAN) ? cnt_reg : IW'(idx_reg);
    assign mem_wr_en   = load && fin_wr;
    assign mem_wr_addr = fin_addr;
    assign mem_wr_data = fin_word;

    assign scan_ctl.clear  = accept;
    assign scan_ctl.sample = pend_reg;

    bclru_mem #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_word (mem_rd_word),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bclru_scan #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (scan_ctl),
        .device       (dev_reg),
        .block_number (blk_reg),
        .word         (mem_rd_word),
        .addr         (pend_addr_reg),
        .hit          (scan_hit),
        .hit_idx      (scan_hit_idx),
        .hit_word     (scan_hit_word),
        .found        (scan_found),
        .pick_idx     (scan_pick_idx),
        .pick_time    (scan_pick_time)
    );

    // result and write-back of the finishing request
    always_comb
    begin
        fin_wr     = 1'b0;
        fin_word   = mem_rd_word;
        fin_addr   = IW'(idx_reg);
        fin_entry  = idx_reg;
        fin_hit    = 1'b0;
        fin_rd     = 1'b0;
        fin_status = ST_OK;
        if (mode_reg == MODE_GET)
        begin
            if (scan_hit)
            begin
                fin_wr     = 1'b1;
                fin_word   = scan_hit_word;
                fin_word.ref_count = (scan_hit_word.ref_count == CNT_MAX) ?
                                     CNT_MAX : scan_hit_word.ref_count + 1'b1;
                fin_word.data_valid = 1'b1;
                fin_addr   = scan_hit_idx;
                fin_entry  = IDX_W'(scan_hit_idx);
                fin_hit    = 1'b1;
                fin_rd     = !scan_hit_word.data_valid;
            end
            else if (scan_found)
            begin
                fin_wr                = 1'b1;
                fin_word.tag_device   = dev_reg;
                fin_word.tag_block    = blk_reg;
                fin_word.ref_count    = CNT_W'(1);
                fin_word.release_time = scan_pick_time;
                fin_word.data_valid   = 1'b1;
                fin_addr              = scan_pick_idx;
                fin_entry             = IDX_W'(scan_pick_idx);
                fin_rd                = 1'b1;
            end
            else
            begin
                fin_entry  = '0;
                fin_status = ST_NO_FREE;
            end
        end
        else if (oor_reg)
        begin
            fin_status = (mode_reg == MODE_PIN) ? ST_OK : ST_ZERO;
        end
        else if (mode_reg == MODE_PIN)
        begin
            fin_wr = 1'b1;
            fin_word.ref_count = (mem_rd_word.ref_count == CNT_MAX) ?
                                 CNT_MAX : mem_rd_word.ref_count + 1'b1;
        end
        else if (mem_rd_word.ref_count == '0)
        begin
            fin_status = ST_ZERO;
        end
        else
        begin
            fin_wr = 1'b1;
            fin_word.ref_count = mem_rd_word.ref_count - 1'b1;
            if ((mode_reg == MODE_RELEASE) && (mem_rd_word.ref_count == CNT_W'(1)))
            begin
                fin_word.release_time = now_reg;
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = (state_reg == S_SCAN);
        pend_addr_next  = cnt_reg;
        mode_next       = mode_reg;
        dev_next        = dev_reg;
        blk_next        = blk_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        oor_next        = oor_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_entry_next  = out_entry_reg;
        out_hit_next    = out_hit_reg;
        out_rd_next     = out_rd_reg;
        out_status_next = out_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next = req.mode;
                    dev_next  = req.device;
                    blk_next  = req.block_number;
                    idx_next  = req.entry_index;
                    now_next  = req.now_tick;
                    oor_next  = int'(req.entry_index) >= NUM_ENTRIES;
                    cnt_next  = '0;
                    if (req.mode == MODE_GET)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (int'(req.entry_index) >= NUM_ENTRIES)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ADDR)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_FINISH;
            end
            S_FETCH:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_entry_next  = fin_entry;
                    out_hit_next    = fin_hit;
                    out_rd_next     = fin_rd;
                    out_status_next = fin_status;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            mode_reg       <= '0;
            dev_reg        <= '0;
            blk_reg        <= '0;
            idx_reg        <= '0;
            now_reg        <= '0;
            oor_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_entry_reg  <= '0;
            out_hit_reg    <= 1'b0;
            out_rd_reg     <= 1'b0;
            out_status_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            mode_reg       <= mode_next;
            dev_reg        <= dev_next;
            blk_reg        <= blk_next;
            idx_reg        <= idx_next;
            now_reg        <= now_next;
            oor_reg        <= oor_next;
            out_valid_reg  <= out_valid_next;
            out_entry_reg  <= out_entry_next;
            out_hit_reg    <= out_hit_next;
            out_rd_reg     <= out_rd_next;
            out_status_reg <= out_status_next;
        end
    end

    // result channel
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_entry = out_entry_reg;
    assign rsp.was_hit      = out_hit_reg;
    assign rsp.needs_read   = out_rd_reg;
    assign rsp.status       = out_status_reg;

`ifndef SYNTHESIS
    // one read and one write port, yet never read and write in one cycle
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en))
        else $error("entry memory read and write in the same cycle");

    // write-back only when the result is loaded
    a_wr_finish: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (state_reg == S_FINISH) && load)
        else $error("entry write outside result load");

    // a get transfer starts the scan
    a_get_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.mode == MODE_GET) |=> (state_reg == S_SCAN) && (cnt_reg == '0))
        else $error("get did not start a scan from entry zero");

    // no sample left in flight when a new request can be taken
    a_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !pend_reg)
        else $error("scan sample pending while idle");

    // a loaded result shows up on the output
    a_load_out: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("result load lost");
`endif

endmodule
